// File: hw/rtl/cwsc_pkg.sv
`default_nettype none
package cwsc_pkg;

   // default sizes
   localparam int CWSC_MAX_VERTICES = 16;
   localparam int CWSC_COORD_BITS   = 16;

   // fixed field widths
   localparam int VC_W  = 5;
   localparam int IDX_W = 4;

   // Q2.16 edge parameter
   localparam int T_W    = 18;
   localparam int T_FRAC = 16;
   localparam logic [T_W-1:0] T_ONE  = 18'h10000;
   localparam logic [T_W-1:0] T_MAX  = 18'h1FFFF;
   localparam logic [T_W-1:0] T_MIN  = 18'h20000;
   localparam int T_HALF = 32768;

   localparam logic [VC_W-1:0] VC_RESET = 5'd4;
   localparam int MIN_VERTICES = 3;

   // sequencing
   localparam int DIV_CNT_W = 5;
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = 5'd17;
   localparam logic [1:0] LERP_LAST = 2'd3;

   typedef enum logic {
      REQ_LOAD  = 1'b0,
      REQ_POINT = 1'b1
   } req_kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_DIFF,
      ST_MUL,
      ST_SUM,
      ST_ABS,
      ST_TEST,
      ST_DIV,
      ST_UPDATE,
      ST_LERP_MUL,
      ST_LERP_ADD,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic take;
      logic mem_read;
      logic diff_en;
      logic mul_en;
      logic sum_en;
      logic abs_en;
      logic div_load;
      logic div_step;
      logic update_en;
      logic edge_next;
      logic lerp_mul;
      logic lerp_add;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic req_valid;
      logic forms_seg;
      logic den_zero;
      logic num_neg;
      logic sat;
      logic div_last;
      logic upd_reject;
      logic last_edge;
      logic lerp_last;
      logic out_free;
   } sts_type;

endpackage
`default_nettype wire

// File: hw/rtl/cwsc_if.sv
`default_nettype none

// request channel
interface cwsc_req_if
   import cwsc_pkg::*;
#(
   parameter int COORD_BITS = CWSC_COORD_BITS
);
   logic                         valid;
   logic                         ready;
   logic                         req_type;
   logic        [IDX_W-1:0]      vertex_index;
   logic signed [COORD_BITS-1:0] point_x;
   logic signed [COORD_BITS-1:0] point_y;
   logic                         new_curve;

   modport source (output valid, req_type, vertex_index, point_x, point_y, new_curve,
                   input ready);
   modport sink   (input valid, req_type, vertex_index, point_x, point_y, new_curve,
                   output ready);
endinterface

// result channel
interface cwsc_rsp_if
#(
   parameter int COORD_BITS = cwsc_pkg::CWSC_COORD_BITS
);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] start_x;
   logic signed [COORD_BITS-1:0] start_y;
   logic signed [COORD_BITS-1:0] end_x;
   logic signed [COORD_BITS-1:0] end_y;

   modport source (output valid, start_x, start_y, end_x, end_y, input ready);
   modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

// register write channel
interface cwsc_csr_if;
   logic                      valid;
   logic                      ready;
   logic [cwsc_pkg::VC_W-1:0] vertex_count;

   modport source (output valid, vertex_count, input ready);
   modport sink   (input valid, vertex_count, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/cwsc_ctrl.sv
`default_nettype none
module cwsc_ctrl
   import cwsc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (sts.req_valid && sts.forms_seg) state_in = ST_READ;
         end
         ST_READ:  state_in = ST_DIFF;
         ST_DIFF:  state_in = ST_MUL;
         ST_MUL:   state_in = ST_SUM;
         ST_SUM:   state_in = ST_ABS;
         ST_ABS:   state_in = ST_TEST;
         ST_TEST: begin
            if (sts.den_zero) begin
               if (sts.num_neg)        state_in = ST_IDLE;
               else if (sts.last_edge) state_in = ST_LERP_MUL;
               else                    state_in = ST_READ;
            end else if (sts.sat) begin
               state_in = ST_UPDATE;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (sts.div_last) state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (sts.upd_reject)     state_in = ST_IDLE;
            else if (sts.last_edge) state_in = ST_LERP_MUL;
            else                    state_in = ST_READ;
         end
         ST_LERP_MUL: state_in = ST_LERP_ADD;
         ST_LERP_ADD: begin
            if (sts.lerp_last) state_in = ST_FINISH;
            else               state_in = ST_LERP_MUL;
         end
         ST_FINISH: begin
            if (sts.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE:     cmd.take      = 1'b1;
         ST_READ:     cmd.mem_read  = 1'b1;
         ST_DIFF:     cmd.diff_en   = 1'b1;
         ST_MUL:      cmd.mul_en    = 1'b1;
         ST_SUM:      cmd.sum_en    = 1'b1;
         ST_ABS:      cmd.abs_en    = 1'b1;
         ST_TEST: begin
            cmd.div_load  = 1'b1;
            cmd.edge_next = sts.den_zero && !sts.num_neg && !sts.last_edge;
         end
         ST_DIV:      cmd.div_step  = 1'b1;
         ST_UPDATE: begin
            cmd.update_en = 1'b1;
            cmd.edge_next = !sts.upd_reject && !sts.last_edge;
         end
         ST_LERP_MUL: cmd.lerp_mul  = 1'b1;
         ST_LERP_ADD: cmd.lerp_add  = 1'b1;
         ST_FINISH:   cmd.out_load  = sts.out_free;
         default:     cmd = '0;
      endcase
   end

   // checks
   a_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> sts.out_free) else $error("result loaded over a pending one");
   a_div_update: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && sts.div_last) |=> state_ff == ST_UPDATE)
      else $error("divider finish not followed by update");
   a_div_nosat: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> !sts.sat) else $error("dividing a saturated quotient");
   a_lerp_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LERP_ADD |-> $past(state_ff) == ST_LERP_MUL)
      else $error("interpolation add without product");

endmodule
`default_nettype wire

// File: hw/rtl/cwsc_dp.sv
`default_nettype none
module cwsc_dp
   import cwsc_pkg::*;
#(
   parameter int MAX_VERTICES = CWSC_MAX_VERTICES,
   parameter int COORD_BITS   = CWSC_COORD_BITS
)(
   input  wire logic   clock,
   input  wire logic   reset,
   cwsc_req_if.sink    req,
   cwsc_rsp_if.source  rsp,
   cwsc_csr_if.sink    csr,
   input  wire cmd_type cmd,
   output sts_type     sts
);

   localparam int CW   = COORD_BITS;
   localparam int DW   = CW + 1;
   localparam int PW   = 2 * DW;
   localparam int SW   = PW + 1;
   localparam int AW   = SW + 1;
   localparam int IW   = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int NW   = $clog2(MAX_VERTICES + 1);
   localparam int CMPW = (NW > VC_W) ? NW : VC_W;
   localparam int XW   = IW + IDX_W;
   localparam int LPW  = T_W + DW;
   localparam int LW   = CW + T_FRAC + LPW + 2;

   // window table
   logic signed [CW-1:0] mem_x [MAX_VERTICES];
   logic signed [CW-1:0] mem_y [MAX_VERTICES];
   logic signed [CW-1:0] vjx_ff, vjy_ff, vkx_ff, vky_ff;

   logic [VC_W-1:0]      vc_ff;
   logic                 have_prev_ff;
   logic signed [CW-1:0] prev_x_ff, prev_y_ff, x1_ff, y1_ff;
   logic signed [DW-1:0] dx_ff, dy_ff, nx_ff, ny_ff, wx_ff, wy_ff;
   logic signed [PW-1:0] pnx_ff, pny_ff, qnx_ff, qny_ff;
   logic signed [SW-1:0] num_ff, den_ff;
   logic [SW-1:0]        a_ff, b_ff;
   logic                 neg_ff, den_neg_ff, num_neg_ff, den_zero_ff, sat_ff;
   logic [AW-1:0]        r_ff;
   logic [T_W-1:0]       q_ff;
   logic [DIV_CNT_W-1:0] div_cnt_ff;
   logic signed [T_W-1:0] te_ff, tl_ff;
   logic [IW-1:0]        j_ff;
   logic [1:0]           lerp_cnt_ff;
   logic signed [LPW-1:0] lprod_ff;
   logic signed [CW-1:0] res_ff [4];
   logic                 rsp_valid_ff;
   logic signed [CW-1:0] out_sx_ff, out_sy_ff, out_ex_ff, out_ey_ff;

   // window size and edge indexes
   logic [CMPW-1:0] n_ext, vc_ext, max_ext;
   logic            small_win, last_edge;
   logic [IW-1:0]   k_idx, waddr;
   logic [XW-1:0]   slot_wide;

   assign vc_ext    = CMPW'(vc_ff);
   assign max_ext   = CMPW'(MAX_VERTICES);
   assign n_ext     = (vc_ext > max_ext) ? max_ext : vc_ext;
   assign small_win = n_ext < CMPW'(MIN_VERTICES);
   assign last_edge = (CMPW'(j_ff) + CMPW'(1)) == n_ext;
   assign k_idx     = last_edge ? '0 : j_ff + IW'(1);
   assign slot_wide = XW'(req.vertex_index);
   assign waddr     = slot_wide[IW-1:0];

   logic transfer, is_point, forms_seg, slot_ok;
   assign transfer  = req.valid && cmd.take;
   assign is_point  = req.req_type == REQ_POINT;
   assign slot_ok   = int'(req.vertex_index) < MAX_VERTICES;
   assign forms_seg = is_point && !req.new_curve && have_prev_ff && !small_win;
   assign req.ready = cmd.take;
   assign csr.ready = 1'b1;

   // register and curve state
   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff        <= VC_RESET;
         have_prev_ff <= 1'b0;
      end else begin
         if (csr.valid) vc_ff <= csr.vertex_count;
         if (transfer && is_point) have_prev_ff <= 1'b1;
      end
   end

   // table write and edge reads
   always_ff @(posedge clock) begin
      if (transfer && !is_point && slot_ok) begin
         mem_x[waddr] <= req.point_x;
         mem_y[waddr] <= req.point_y;
      end
      if (cmd.mem_read) begin
         vjx_ff <= mem_x[j_ff];
         vjy_ff <= mem_y[j_ff];
         vkx_ff <= mem_x[k_idx];
         vky_ff <= mem_y[k_idx];
      end
   end

   // segment start and edge counter
   always_ff @(posedge clock) begin
      if (transfer && is_point) begin
         prev_x_ff <= req.point_x;
         prev_y_ff <= req.point_y;
      end
      if (transfer && forms_seg) begin
         x1_ff       <= prev_x_ff;
         y1_ff       <= prev_y_ff;
         dx_ff       <= DW'(req.point_x) - DW'(prev_x_ff);
         dy_ff       <= DW'(req.point_y) - DW'(prev_y_ff);
         j_ff        <= '0;
      end
      if (cmd.edge_next) j_ff <= j_ff + IW'(1);
   end

   // edge normal and dot products
   always_ff @(posedge clock) begin
      if (cmd.diff_en) begin
         nx_ff <= DW'(vky_ff) - DW'(vjy_ff);
         ny_ff <= DW'(vjx_ff) - DW'(vkx_ff);
         wx_ff <= DW'(vjx_ff) - DW'(x1_ff);
         wy_ff <= DW'(vjy_ff) - DW'(y1_ff);
      end
      if (cmd.mul_en) begin
         pnx_ff <= nx_ff * wx_ff;
         pny_ff <= ny_ff * wy_ff;
         qnx_ff <= nx_ff * dx_ff;
         qny_ff <= ny_ff * dy_ff;
      end
      if (cmd.sum_en) begin
         num_ff <= SW'(pnx_ff) + SW'(pny_ff);
         den_ff <= SW'(qnx_ff) + SW'(qny_ff);
      end
      if (cmd.abs_en) begin
         a_ff        <= num_ff[SW-1] ? $unsigned(-num_ff) : $unsigned(num_ff);
         b_ff        <= den_ff[SW-1] ? $unsigned(-den_ff) : $unsigned(den_ff);
         neg_ff      <= num_ff[SW-1] ^ den_ff[SW-1];
         den_neg_ff  <= den_ff[SW-1];
         num_neg_ff  <= num_ff[SW-1];
         den_zero_ff <= den_ff == '0;
      end
   end

   // restoring divider, one quotient bit a cycle
   logic [AW-1:0] rr, bw;
   logic          ge, sat_now;
   assign bw      = {1'b0, b_ff};
   assign rr      = (div_cnt_ff == '0) ? r_ff : {r_ff[AW-2:0], 1'b0};
   assign ge      = rr >= bw;
   assign sat_now = {1'b0, a_ff} >= {b_ff, 1'b0};

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         sat_ff     <= sat_now;
         r_ff       <= {1'b0, a_ff};
         q_ff       <= '0;
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         r_ff       <= ge ? rr - bw : rr;
         q_ff       <= {q_ff[T_W-2:0], ge};
         div_cnt_ff <= div_cnt_ff + DIV_CNT_W'(1);
      end
   end

   // round, saturate and narrow the interval
   logic [T_W:0]          q1;
   logic [T_W-1:0]        mag, mag_pos;
   logic signed [T_W-1:0] t_val, te_new, tl_new;
   assign q1      = {1'b0, q_ff} + (T_W+1)'(1);
   assign mag     = q1[T_W:1];
   assign mag_pos = (mag > T_MAX) ? T_MAX : mag;
   always_comb begin
      if (sat_ff) t_val = neg_ff ? T_MIN : T_MAX;
      else        t_val = neg_ff ? -mag : mag_pos;
   end
   assign te_new = (den_neg_ff && t_val > te_ff) ? t_val : te_ff;
   assign tl_new = (!den_neg_ff && t_val < tl_ff) ? t_val : tl_ff;

   always_ff @(posedge clock) begin
      if (transfer && forms_seg) begin
         te_ff <= '0;
         tl_ff <= T_ONE;
      end else if (cmd.update_en) begin
         te_ff <= te_new;
         tl_ff <= tl_new;
      end
   end

   // endpoint interpolation, one coordinate per pass
   logic signed [T_W-1:0] lt;
   logic signed [DW-1:0]  ld;
   logic signed [CW-1:0]  lp;
   logic signed [LW-1:0]  lp_ext, lv;
   assign lt     = lerp_cnt_ff[1] ? tl_ff : te_ff;
   assign ld     = lerp_cnt_ff[0] ? dy_ff : dx_ff;
   assign lp     = lerp_cnt_ff[0] ? y1_ff : x1_ff;
   assign lp_ext = LW'(lp);
   assign lv     = (lp_ext <<< T_FRAC) + LW'(lprod_ff) + LW'(T_HALF);

   always_ff @(posedge clock) begin
      if (cmd.lerp_mul) lprod_ff <= lt * ld;
      if (cmd.lerp_add) res_ff[lerp_cnt_ff] <= lv[T_FRAC+CW-1:T_FRAC];
      if (transfer && forms_seg) begin
         lerp_cnt_ff <= '0;
      end else if (cmd.lerp_add) begin
         lerp_cnt_ff <= lerp_cnt_ff + 2'd1;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_sx_ff <= res_ff[0];
         out_sy_ff <= res_ff[1];
         out_ex_ff <= res_ff[2];
         out_ey_ff <= res_ff[3];
      end
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.start_x = out_sx_ff;
   assign rsp.start_y = out_sy_ff;
   assign rsp.end_x   = out_ex_ff;
   assign rsp.end_y   = out_ey_ff;

   // status to the controller
   assign sts.req_valid  = req.valid;
   assign sts.forms_seg  = forms_seg;
   assign sts.den_zero   = den_zero_ff;
   assign sts.num_neg    = num_neg_ff;
   assign sts.sat        = sat_now;
   assign sts.div_last   = div_cnt_ff == DIV_LAST;
   assign sts.upd_reject = te_new > tl_new;
   assign sts.last_edge  = last_edge;
   assign sts.lerp_last  = lerp_cnt_ff == LERP_LAST;
   assign sts.out_free   = !rsp_valid_ff || rsp.ready;

endmodule
`default_nettype wire

// File: hw/rtl/convex_window_segment_clipper.sv
// Convex window segment clipper (Cyrus-Beck, fixed point).
// req_bus carries load items (req_type 0: write window vertex vertex_index)
// and curve points (req_type 1). A point joins the previous point into a
// segment unless new_curve is set. csr_bus writes vertex_count, the number
// of window vertices in use; it is always ready. The user must write it
// only while idle; the block does not enforce this. rsp_bus returns one
// clipped segment (rounded start and end points) for each visible segment,
// and nothing for rejected ones. Load items and points that form no
// segment are taken without leaving the idle state. Each edge runs read,
// difference, product, sum, magnitude and test steps, then, unless
// parallel, the update, after the divider (one quotient bit a cycle)
// unless the quotient saturates. Clipping stops at the first edge that
// rejects; after the last edge the four endpoint coordinates are
// interpolated, each by a multiply and an add. One segment is processed
// at a time. Reset clears the curve state and sets vertex_count to 4; the
// vertex table holds nothing valid until written. The result sits in an
// output register; a new item is taken while it waits, and the block holds
// only when a further result is ready while the receiver still stalls.
`default_nettype none
module convex_window_segment_clipper
   import cwsc_pkg::*;
#(
   parameter int MAX_VERTICES = CWSC_MAX_VERTICES,
   parameter int COORD_BITS   = CWSC_COORD_BITS
)(
   input  wire logic  clock,
   input  wire logic  reset,
   cwsc_req_if.sink   req_bus,
   cwsc_rsp_if.source rsp_bus,
   cwsc_csr_if.sink   csr_bus
);

   cmd_type cmd;
   sts_type sts;

   // sequencer
   cwsc_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd)
   );

   // table, arithmetic and output register
   cwsc_dp #(
      .MAX_VERTICES (MAX_VERTICES),
      .COORD_BITS   (COORD_BITS)
   ) u_dp (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus),
      .csr   (csr_bus),
      .cmd   (cmd),
      .sts   (sts)
   );

endmodule
`default_nettype wire
